@@ rtl/circle_pair_collision_resolve_assert.svh @@
// ---------------------------------------------------------------------------
// circle pair collision resolve assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_ASSERT_SVH

// same-cycle implication, off during reset
`define CPCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpcr check failed");

// next-cycle implication, off during reset
`define CPCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpcr check failed");

// state in the cycle after a reset cycle
`define CPCR_ASSERT_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("cpcr reset check failed");

`endif

@@ rtl/cpcr_pkg.sv @@
// ---------------------------------------------------------------------------
// cpcr_pkg
// widths, pipeline payload types and helpers for the collision pipeline
// ---------------------------------------------------------------------------
package cpcr_pkg;

  localparam int COORD_W  = 32;
  localparam int RAD_W    = 24;
  localparam int MIND_W   = RAD_W + 1;
  localparam int MAG_W    = MIND_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = FRAC_W + 1;
  localparam int NORM_W   = QUO_W + 1;
  localparam int SEP_W    = MIND_W - 1;
  localparam int WIDE_W   = 40;

  localparam int FRONT_STAGES   = 4;
  localparam int SQRT_STEPS     = MAG_W;
  localparam int DIV_STEPS      = QUO_W;
  localparam int RESOLVE_STAGES = 5;
  localparam int PIPE_STAGES    = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + RESOLVE_STAGES;
  localparam int STEP_W         = 5;
  localparam int SQRT_TOP       = 2 * (SQRT_STEPS - 1);

  localparam logic signed [WIDE_W-1:0] SAT_HI = 40'sh00_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_LO = 40'shFF_8000_0000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
  } cpcr_circle_t;

  typedef struct packed {
    cpcr_circle_t c1;
    cpcr_circle_t c2;
  } cpcr_pair_t;

  // carried through the square root steps
  typedef struct packed {
    cpcr_pair_t          pair;
    logic                neg_x;
    logic                neg_y;
    logic [MAG_W-1:0]    adx;
    logic [MAG_W-1:0]    ady;
    logic [MIND_W-1:0]   mind;
    logic                contact;
    logic [SQ_W-1:0]     rem;
    logic [SQ_W-1:0]     root;
  } cpcr_sqrt_t;

  // carried through the divider steps
  typedef struct packed {
    cpcr_pair_t          pair;
    logic                neg_x;
    logic                neg_y;
    logic                lsb_x;
    logic                lsb_y;
    logic                contact;
    logic [MAG_W-1:0]    span;
    logic [SEP_W-1:0]    sep;
    logic [MAG_W-1:0]    rx;
    logic [MAG_W-1:0]    ry;
    logic [QUO_W-1:0]    qx;
    logic [QUO_W-1:0]    qy;
  } cpcr_div_t;

  typedef struct packed {
    cpcr_pair_t pair;
    logic       overlapping;
    logic       impulse;
  } cpcr_result_t;

  // clamp to the signed 32-bit range
  function automatic logic [COORD_W-1:0] cpcr_sat(input logic signed [WIDE_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // hand the square root result over to the divider
  function automatic cpcr_div_t cpcr_div_init(input cpcr_sqrt_t s);
    cpcr_div_t          d;
    logic [MIND_W-1:0]  diff;
    diff      = s.mind - s.root[MAG_W-1:0];
    d.pair    = s.pair;
    d.neg_x   = s.neg_x;
    d.neg_y   = s.neg_y;
    d.lsb_x   = s.adx[0];
    d.lsb_y   = s.ady[0];
    d.contact = s.contact;
    d.span    = s.root[MAG_W-1:0];
    d.sep     = diff[MIND_W-1:1];
    d.rx      = {1'b0, s.adx[MAG_W-1:1]};
    d.ry      = {1'b0, s.ady[MAG_W-1:1]};
    d.qx      = '0;
    d.qy      = '0;
    return d;
  endfunction

endpackage

@@ rtl/cpcr_if.sv @@
// ---------------------------------------------------------------------------
// cpcr channel interfaces
// valid/ready channels for circle pairs in and resolved pairs out
// ---------------------------------------------------------------------------
interface cpcr_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_vx;
  logic signed [31:0] first_vy;
  logic [23:0] first_radius;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_vx;
  logic signed [31:0] second_vy;
  logic [23:0] second_radius;

  modport source (
    output valid, first_x, first_y, first_vx, first_vy, first_radius,
           second_x, second_y, second_vx, second_vy, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_vx, first_vy, first_radius,
           second_x, second_y, second_vx, second_vy, second_radius,
    output ready
  );
endinterface

interface cpcr_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] new_first_x;
  logic signed [31:0] new_first_y;
  logic signed [31:0] new_first_vx;
  logic signed [31:0] new_first_vy;
  logic signed [31:0] new_second_x;
  logic signed [31:0] new_second_y;
  logic signed [31:0] new_second_vx;
  logic signed [31:0] new_second_vy;
  logic        overlapping;
  logic        impulse_applied;

  modport source (
    output valid, new_first_x, new_first_y, new_first_vx, new_first_vy,
           new_second_x, new_second_y, new_second_vx, new_second_vy,
           overlapping, impulse_applied,
    input  ready
  );
  modport sink (
    input  valid, new_first_x, new_first_y, new_first_vx, new_first_vy,
           new_second_x, new_second_y, new_second_vx, new_second_vy,
           overlapping, impulse_applied,
    output ready
  );
endinterface

@@ rtl/cpcr_front.sv @@
// ---------------------------------------------------------------------------
// cpcr_front
// deltas, radius sum, bounding test, squares and exact contact test
// ---------------------------------------------------------------------------
module cpcr_front (
  input  logic                            clk,
  input  logic                            en,
  input  cpcr_pkg::cpcr_pair_t            pair_in,
  input  logic [cpcr_pkg::RAD_W-1:0]      r1_in,
  input  logic [cpcr_pkg::RAD_W-1:0]      r2_in,
  output cpcr_pkg::cpcr_sqrt_t            sq_out
);

  localparam int DW = cpcr_pkg::COORD_W + 1;

  // stage 1 registers
  cpcr_pkg::cpcr_pair_t              s1_pair_r;
  logic signed [DW-1:0]              s1_dx_r, s1_dy_r;
  logic [cpcr_pkg::MIND_W-1:0]       s1_mind_r;
  // stage 2 registers
  cpcr_pkg::cpcr_pair_t              s2_pair_r;
  logic                              s2_neg_x_r, s2_neg_y_r, s2_near_r;
  logic [cpcr_pkg::MAG_W-1:0]        s2_adx_r, s2_ady_r;
  logic [cpcr_pkg::MIND_W-1:0]       s2_mind_r;
  // stage 3 registers
  cpcr_pkg::cpcr_pair_t              s3_pair_r;
  logic                              s3_neg_x_r, s3_neg_y_r, s3_near_r;
  logic [cpcr_pkg::MAG_W-1:0]        s3_adx_r, s3_ady_r;
  logic [cpcr_pkg::MIND_W-1:0]       s3_mind_r;
  logic [cpcr_pkg::SQ_W-1:0]         s3_dx2_r, s3_dy2_r, s3_m2_r;
  // stage 4 register
  cpcr_pkg::cpcr_sqrt_t              s4_r;

  logic signed [DW-1:0]              dx_c, dy_c;
  logic [DW-1:0]                     adx_c, ady_c;
  logic [cpcr_pkg::SQ_W:0]           d2_c;
  logic                              contact_c;

  // exact centre deltas
  assign dx_c = $signed({pair_in.c2.x[31], pair_in.c2.x}) -
                $signed({pair_in.c1.x[31], pair_in.c1.x});
  assign dy_c = $signed({pair_in.c2.y[31], pair_in.c2.y}) -
                $signed({pair_in.c1.y[31], pair_in.c1.y});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pair_r <= pair_in;
      s1_dx_r   <= dx_c;
      s1_dy_r   <= dy_c;
      s1_mind_r <= {1'b0, r1_in} + {1'b0, r2_in};
    end
  end

  // magnitudes and bounding box test
  assign adx_c = s1_dx_r[DW-1] ? DW'(-s1_dx_r) : DW'(s1_dx_r);
  assign ady_c = s1_dy_r[DW-1] ? DW'(-s1_dy_r) : DW'(s1_dy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pair_r  <= s1_pair_r;
      s2_neg_x_r <= s1_dx_r[DW-1];
      s2_neg_y_r <= s1_dy_r[DW-1];
      s2_adx_r   <= adx_c[cpcr_pkg::MAG_W-1:0];
      s2_ady_r   <= ady_c[cpcr_pkg::MAG_W-1:0];
      s2_mind_r  <= s1_mind_r;
      s2_near_r  <= (adx_c < DW'(s1_mind_r)) && (ady_c < DW'(s1_mind_r));
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      s3_pair_r  <= s2_pair_r;
      s3_neg_x_r <= s2_neg_x_r;
      s3_neg_y_r <= s2_neg_y_r;
      s3_near_r  <= s2_near_r;
      s3_adx_r   <= s2_adx_r;
      s3_ady_r   <= s2_ady_r;
      s3_mind_r  <= s2_mind_r;
      s3_dx2_r   <= s2_adx_r * s2_adx_r;
      s3_dy2_r   <= s2_ady_r * s2_ady_r;
      s3_m2_r    <= s2_mind_r * s2_mind_r;
    end
  end

  // squared distance against squared radius sum
  assign d2_c      = {1'b0, s3_dx2_r} + {1'b0, s3_dy2_r};
  assign contact_c = s3_near_r && (d2_c != '0) && (d2_c < {1'b0, s3_m2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r.pair    <= s3_pair_r;
      s4_r.neg_x   <= s3_neg_x_r;
      s4_r.neg_y   <= s3_neg_y_r;
      s4_r.adx     <= s3_adx_r;
      s4_r.ady     <= s3_ady_r;
      s4_r.mind    <= s3_mind_r;
      s4_r.contact <= contact_c;
      s4_r.rem     <= d2_c[cpcr_pkg::SQ_W-1:0];
      s4_r.root    <= '0;
    end
  end

  assign sq_out = s4_r;

endmodule

@@ rtl/cpcr_sqrt_step.sv @@
// ---------------------------------------------------------------------------
// cpcr_sqrt_step
// one result bit of the integer square root, registered
// ---------------------------------------------------------------------------
module cpcr_sqrt_step (
  input  logic                         clk,
  input  logic                         en,
  input  logic [cpcr_pkg::STEP_W-1:0]  step,
  input  cpcr_pkg::cpcr_sqrt_t         d_in,
  output cpcr_pkg::cpcr_sqrt_t         d_out
);

  logic [5:0]                    shamt_c;
  logic [cpcr_pkg::SQ_W-1:0]     one_c;
  logic [cpcr_pkg::SQ_W:0]       trial_c;
  logic                          ge_c;
  cpcr_pkg::cpcr_sqrt_t          d_nxt, d_r;

  // trial subtract of root plus the current bit
  assign shamt_c = 6'(cpcr_pkg::SQRT_TOP) - {step, 1'b0};
  assign one_c   = cpcr_pkg::SQ_W'(1) << shamt_c;
  assign trial_c = {1'b0, d_in.root} + {1'b0, one_c};
  assign ge_c    = {1'b0, d_in.rem} >= trial_c;

  always_comb begin
    d_nxt = d_in;
    if (ge_c) begin
      d_nxt.rem  = d_in.rem - trial_c[cpcr_pkg::SQ_W-1:0];
      d_nxt.root = (d_in.root >> 1) + one_c;
    end else begin
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

@@ rtl/cpcr_div_step.sv @@
// ---------------------------------------------------------------------------
// cpcr_div_step
// one quotient bit of both normal divisions, restoring, registered
// ---------------------------------------------------------------------------
module cpcr_div_step (
  input  logic                         clk,
  input  logic                         en,
  input  logic [cpcr_pkg::STEP_W-1:0]  step,
  input  cpcr_pkg::cpcr_div_t          d_in,
  output cpcr_pkg::cpcr_div_t          d_out
);

  localparam int MW = cpcr_pkg::MAG_W;

  logic            inx_c, iny_c, gex_c, gey_c;
  logic [MW:0]     rx2_c, ry2_c, subx_c, suby_c;
  cpcr_pkg::cpcr_div_t d_nxt, d_r;

  // only the first step brings in a dividend bit, the rest shift in zeros
  assign inx_c  = (step == '0) ? d_in.lsb_x : 1'b0;
  assign iny_c  = (step == '0) ? d_in.lsb_y : 1'b0;
  assign rx2_c  = {d_in.rx, inx_c};
  assign ry2_c  = {d_in.ry, iny_c};
  assign subx_c = rx2_c - {1'b0, d_in.span};
  assign suby_c = ry2_c - {1'b0, d_in.span};
  assign gex_c  = rx2_c >= {1'b0, d_in.span};
  assign gey_c  = ry2_c >= {1'b0, d_in.span};

  always_comb begin
    d_nxt    = d_in;
    d_nxt.rx = gex_c ? subx_c[MW-1:0] : rx2_c[MW-1:0];
    d_nxt.ry = gey_c ? suby_c[MW-1:0] : ry2_c[MW-1:0];
    d_nxt.qx = {d_in.qx[cpcr_pkg::QUO_W-2:0], gex_c};
    d_nxt.qy = {d_in.qy[cpcr_pkg::QUO_W-2:0], gey_c};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

@@ rtl/cpcr_resolve.sv @@
// ---------------------------------------------------------------------------
// cpcr_resolve
// signed normal, separation push and equal mass velocity exchange
// ---------------------------------------------------------------------------
module cpcr_resolve (
  input  logic                  clk,
  input  logic                  en,
  input  cpcr_pkg::cpcr_div_t   d_in,
  output cpcr_pkg::cpcr_result_t res_out
);

  localparam int NW = cpcr_pkg::NORM_W;
  localparam int FW = cpcr_pkg::FRAC_W;
  localparam int WW = cpcr_pkg::WIDE_W;

  // stage 1
  cpcr_pkg::cpcr_pair_t          r1_pair_r;
  logic                          r1_contact_r;
  logic [cpcr_pkg::SEP_W-1:0]    r1_sep_r;
  logic signed [NW-1:0]          r1_nx_r, r1_ny_r;
  logic signed [32:0]            r1_dvx_r, r1_dvy_r;
  // stage 2
  cpcr_pkg::cpcr_pair_t          r2_pair_r;
  logic                          r2_contact_r;
  logic signed [NW-1:0]          r2_nx_r, r2_ny_r;
  logic signed [42:0]            r2_psx_r, r2_psy_r;
  logic signed [50:0]            r2_pdx_r, r2_pdy_r;
  // stage 3
  cpcr_pkg::cpcr_pair_t          r3_pair_r;
  logic                          r3_contact_r, r3_imp_r;
  logic signed [NW-1:0]          r3_nx_r, r3_ny_r;
  logic signed [35:0]            r3_dot_r;
  // stage 4
  cpcr_pkg::cpcr_pair_t          r4_pair_r;
  logic                          r4_contact_r, r4_imp_r;
  logic signed [53:0]            r4_ix_r, r4_iy_r;
  // stage 5
  cpcr_pkg::cpcr_result_t        r5_r;

  logic signed [NW-1:0]          nx_c, ny_c;
  logic signed [42:0]            psx_c, psy_c;
  logic signed [50:0]            pdx_c, pdy_c;
  logic signed [26:0]            sx_c, sy_c;
  logic signed [51:0]            dsum_c;
  logic signed [35:0]            dot_c;
  logic signed [WW-1:0]          x1_c, y1_c, x2_c, y2_c;
  logic signed [53:0]            ix_c, iy_c;
  logic signed [37:0]            ixs_c, iys_c;
  logic signed [WW-1:0]          vx1_c, vy1_c, vx2_c, vy2_c;
  cpcr_pkg::cpcr_pair_t          pos_nxt, vel_nxt;

  // signed normal and velocity difference
  assign nx_c = d_in.neg_x ? -$signed({1'b0, d_in.qx}) : $signed({1'b0, d_in.qx});
  assign ny_c = d_in.neg_y ? -$signed({1'b0, d_in.qy}) : $signed({1'b0, d_in.qy});

  always_ff @(posedge clk) begin
    if (en) begin
      r1_pair_r    <= d_in.pair;
      r1_contact_r <= d_in.contact;
      r1_sep_r     <= d_in.sep;
      r1_nx_r      <= nx_c;
      r1_ny_r      <= ny_c;
      r1_dvx_r     <= $signed({d_in.pair.c1.vx[31], d_in.pair.c1.vx}) -
                      $signed({d_in.pair.c2.vx[31], d_in.pair.c2.vx});
      r1_dvy_r     <= $signed({d_in.pair.c1.vy[31], d_in.pair.c1.vy}) -
                      $signed({d_in.pair.c2.vy[31], d_in.pair.c2.vy});
    end
  end

  // push and dot products
  assign psx_c = $signed({1'b0, r1_sep_r}) * r1_nx_r;
  assign psy_c = $signed({1'b0, r1_sep_r}) * r1_ny_r;
  assign pdx_c = r1_dvx_r * r1_nx_r;
  assign pdy_c = r1_dvy_r * r1_ny_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_pair_r    <= r1_pair_r;
      r2_contact_r <= r1_contact_r;
      r2_nx_r      <= r1_nx_r;
      r2_ny_r      <= r1_ny_r;
      r2_psx_r     <= psx_c;
      r2_psy_r     <= psy_c;
      r2_pdx_r     <= pdx_c;
      r2_pdy_r     <= pdy_c;
    end
  end

  // separated centres, floor of the normal velocity
  assign sx_c   = r2_psx_r[42:FW];
  assign sy_c   = r2_psy_r[42:FW];
  assign x1_c   = $signed({{8{r2_pair_r.c1.x[31]}}, r2_pair_r.c1.x}) - $signed({{13{sx_c[26]}}, sx_c});
  assign y1_c   = $signed({{8{r2_pair_r.c1.y[31]}}, r2_pair_r.c1.y}) - $signed({{13{sy_c[26]}}, sy_c});
  assign x2_c   = $signed({{8{r2_pair_r.c2.x[31]}}, r2_pair_r.c2.x}) + $signed({{13{sx_c[26]}}, sx_c});
  assign y2_c   = $signed({{8{r2_pair_r.c2.y[31]}}, r2_pair_r.c2.y}) + $signed({{13{sy_c[26]}}, sy_c});
  assign dsum_c = {r2_pdx_r[50], r2_pdx_r} + {r2_pdy_r[50], r2_pdy_r};
  assign dot_c  = dsum_c[51:FW];

  always_comb begin
    pos_nxt = r2_pair_r;
    if (r2_contact_r) begin
      pos_nxt.c1.x = cpcr_pkg::cpcr_sat(x1_c);
      pos_nxt.c1.y = cpcr_pkg::cpcr_sat(y1_c);
      pos_nxt.c2.x = cpcr_pkg::cpcr_sat(x2_c);
      pos_nxt.c2.y = cpcr_pkg::cpcr_sat(y2_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_pair_r    <= pos_nxt;
      r3_contact_r <= r2_contact_r;
      r3_imp_r     <= r2_contact_r && !dot_c[35] && (dot_c != '0);
      r3_nx_r      <= r2_nx_r;
      r3_ny_r      <= r2_ny_r;
      r3_dot_r     <= dot_c;
    end
  end

  // impulse along the normal
  assign ix_c = r3_dot_r * r3_nx_r;
  assign iy_c = r3_dot_r * r3_ny_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r4_pair_r    <= r3_pair_r;
      r4_contact_r <= r3_contact_r;
      r4_imp_r     <= r3_imp_r;
      r4_ix_r      <= ix_c;
      r4_iy_r      <= iy_c;
    end
  end

  // exchanged velocities
  assign ixs_c = r4_ix_r[53:FW];
  assign iys_c = r4_iy_r[53:FW];
  assign vx1_c = $signed({{8{r4_pair_r.c1.vx[31]}}, r4_pair_r.c1.vx}) - $signed({{2{ixs_c[37]}}, ixs_c});
  assign vy1_c = $signed({{8{r4_pair_r.c1.vy[31]}}, r4_pair_r.c1.vy}) - $signed({{2{iys_c[37]}}, iys_c});
  assign vx2_c = $signed({{8{r4_pair_r.c2.vx[31]}}, r4_pair_r.c2.vx}) + $signed({{2{ixs_c[37]}}, ixs_c});
  assign vy2_c = $signed({{8{r4_pair_r.c2.vy[31]}}, r4_pair_r.c2.vy}) + $signed({{2{iys_c[37]}}, iys_c});

  always_comb begin
    vel_nxt = r4_pair_r;
    if (r4_imp_r) begin
      vel_nxt.c1.vx = cpcr_pkg::cpcr_sat(vx1_c);
      vel_nxt.c1.vy = cpcr_pkg::cpcr_sat(vy1_c);
      vel_nxt.c2.vx = cpcr_pkg::cpcr_sat(vx2_c);
      vel_nxt.c2.vy = cpcr_pkg::cpcr_sat(vy2_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_r.pair        <= vel_nxt;
      r5_r.overlapping <= r4_contact_r;
      r5_r.impulse     <= r4_imp_r;
    end
  end

  assign res_out = r5_r;

endmodule

@@ rtl/circle_pair_collision_resolve.sv @@
// A result passes through 51 pipeline stages and an output register from input transfer to result valid.
// Throughput: one circle pair per cycle while the skid entry is free; depth is set by the 25-stage square root
// and the 17-stage normal divider, one result bit per stage.
// The pipeline stalls as a whole only when the output register and its skid entry are both full.
// Synchronous active-low reset clears all stage valid bits and the output and skid entry valid flags.
// ---------------------------------------------------------------------------
// circle_pair_collision_resolve
// equal mass elastic contact resolution for two circles, Q16.16
// ---------------------------------------------------------------------------
module circle_pair_collision_resolve (
  input  logic           clk,
  input  logic           rst_n,
  cpcr_in_if.sink        in_chan,
  cpcr_out_if.source     out_chan
);

  localparam int NS = cpcr_pkg::PIPE_STAGES;

  logic [NS-1:0]              vld_r;
  logic                       en;
  logic                       take;
  cpcr_pkg::cpcr_pair_t       pair_in;
  cpcr_pkg::cpcr_sqrt_t       sq_chain [cpcr_pkg::SQRT_STEPS+1];
  cpcr_pkg::cpcr_div_t        dv_chain [cpcr_pkg::DIV_STEPS+1];
  cpcr_pkg::cpcr_result_t     res;
  logic                       out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  cpcr_pkg::cpcr_result_t     out_r, out_nxt, skid_r, skid_nxt;

  // pipeline advances while the skid entry is free
  assign en            = !skid_vld_r;
  assign in_chan.ready = en;
  assign take          = en && vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_chan.valid};
    end
  end

  // input payload
  assign pair_in.c1.x  = in_chan.first_x;
  assign pair_in.c1.y  = in_chan.first_y;
  assign pair_in.c1.vx = in_chan.first_vx;
  assign pair_in.c1.vy = in_chan.first_vy;
  assign pair_in.c2.x  = in_chan.second_x;
  assign pair_in.c2.y  = in_chan.second_y;
  assign pair_in.c2.vx = in_chan.second_vx;
  assign pair_in.c2.vy = in_chan.second_vy;

  cpcr_front u_front (
    .clk     (clk),
    .en      (en),
    .pair_in (pair_in),
    .r1_in   (in_chan.first_radius),
    .r2_in   (in_chan.second_radius),
    .sq_out  (sq_chain[0])
  );

  // square root, one bit per stage
  for (genvar g = 0; g < cpcr_pkg::SQRT_STEPS; g++) begin : g_sqrt
    cpcr_sqrt_step u_step (
      .clk   (clk),
      .en    (en),
      .step  (cpcr_pkg::STEP_W'(g)),
      .d_in  (sq_chain[g]),
      .d_out (sq_chain[g+1])
    );
  end

  assign dv_chain[0] = cpcr_pkg::cpcr_div_init(sq_chain[cpcr_pkg::SQRT_STEPS]);

  // normal division, one quotient bit per stage
  for (genvar g = 0; g < cpcr_pkg::DIV_STEPS; g++) begin : g_div
    cpcr_div_step u_step (
      .clk   (clk),
      .en    (en),
      .step  (cpcr_pkg::STEP_W'(g)),
      .d_in  (dv_chain[g]),
      .d_out (dv_chain[g+1])
    );
  end

  cpcr_resolve u_resolve (
    .clk     (clk),
    .en      (en),
    .d_in    (dv_chain[cpcr_pkg::DIV_STEPS]),
    .res_out (res)
  );

  // output register with one skid entry
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_chan.ready) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else if (take) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (take) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // result payload
  assign out_chan.valid           = out_vld_r;
  assign out_chan.new_first_x     = out_r.pair.c1.x;
  assign out_chan.new_first_y     = out_r.pair.c1.y;
  assign out_chan.new_first_vx    = out_r.pair.c1.vx;
  assign out_chan.new_first_vy    = out_r.pair.c1.vy;
  assign out_chan.new_second_x    = out_r.pair.c2.x;
  assign out_chan.new_second_y    = out_r.pair.c2.y;
  assign out_chan.new_second_vx   = out_r.pair.c2.vx;
  assign out_chan.new_second_vy   = out_r.pair.c2.vy;
  assign out_chan.overlapping     = out_r.overlapping;
  assign out_chan.impulse_applied = out_r.impulse;

endmodule

@@ rtl/cpcr_checker.sv @@
// ---------------------------------------------------------------------------
// cpcr_checker
// port level checks on the collision block, bound to the top level
// ---------------------------------------------------------------------------
`include "circle_pair_collision_resolve_assert.svh"

module cpcr_checker (
  input  logic        clk,
  input  logic        rst_n,
  cpcr_in_if.sink     in_chan,
  cpcr_out_if.source  out_chan
);

  // an exchange only happens on an overlapping pair
  `CPCR_ASSERT_IMP(a_impulse_needs_overlap, clk, rst_n, out_chan.valid && out_chan.impulse_applied, out_chan.overlapping)

  // a stalled result holds
  `CPCR_ASSERT_NXT(a_out_hold, clk, rst_n, out_chan.valid && !out_chan.ready, out_chan.valid && $stable(out_chan.new_first_x) && $stable(out_chan.new_second_vy) && $stable(out_chan.overlapping))

  // reset empties the result side
  `CPCR_ASSERT_RST(a_reset_clears_out, clk, rst_n, !out_chan.valid)

  // reset leaves the input side open
  `CPCR_ASSERT_RST(a_ready_after_reset, clk, rst_n, in_chan.ready)

endmodule

bind circle_pair_collision_resolve cpcr_checker u_cpcr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// circle pair collision resolve testbench
// drives circle pairs through the valid/ready input channel, predicts each
// resolved pair in a scoreboard class and checks every output transfer
// field by field, with random idling on both channels
// ---------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic signed [cpcr_pkg::COORD_W-1:0] x1, y1, vx1, vy1;
    logic        [cpcr_pkg::RAD_W-1:0]   r1;
    logic signed [cpcr_pkg::COORD_W-1:0] x2, y2, vx2, vy2;
    logic        [cpcr_pkg::RAD_W-1:0]   r2;
  } circle_pair_t;

  typedef struct {
    logic signed [cpcr_pkg::COORD_W-1:0] x1, y1, vx1, vy1, x2, y2, vx2, vy2;
    logic                                overlapping;
    logic                                impulse;
  } resolved_pair_t;

  // expected resolved pairs, oldest first
  class contact_scoreboard;
    resolved_pair_t pending[$];
    int             errors = 0;

    function logic signed [cpcr_pkg::COORD_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[cpcr_pkg::COORD_W-1:0];
    endfunction

    function longint int_sqrt(longint n);
      longint res;
      longint b;
      res = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n   = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // separation along the normal and equal mass exchange of normal velocity
    function resolved_pair_t resolve_contact(circle_pair_t p);
      resolved_pair_t r;
      longint x1, y1, vx1, vy1, x2, y2, vx2, vy2;
      longint dx, dy, mind, adx, ady, d2, span, nx, ny, sep, sx, sy, dot, ix, iy;
      x1 = p.x1; y1 = p.y1; vx1 = p.vx1; vy1 = p.vy1;
      x2 = p.x2; y2 = p.y2; vx2 = p.vx2; vy2 = p.vy2;
      dx = x2 - x1;
      dy = y2 - y1;
      mind = longint'(p.r1) + longint'(p.r2);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      r.overlapping = 1'b0;
      r.impulse = 1'b0;
      if (adx < mind && ady < mind) begin
        d2 = dx * dx + dy * dy;
        // coincident centres count as no contact
        if (d2 != 0 && d2 < mind * mind) begin
          r.overlapping = 1'b1;
          span = int_sqrt(d2);
          nx = (dx * 65536) / span;
          ny = (dy * 65536) / span;
          sep = (mind - span) / 2;
          sx = (sep * nx) >>> 16;
          sy = (sep * ny) >>> 16;
          x1 -= sx; y1 -= sy; x2 += sx; y2 += sy;
          dot = ((vx1 - vx2) * nx + (vy1 - vy2) * ny) >>> 16;
          // only approaching circles exchange velocity
          if (dot > 0) begin
            ix = (dot * nx) >>> 16;
            iy = (dot * ny) >>> 16;
            vx1 -= ix; vy1 -= iy; vx2 += ix; vy2 += iy;
            r.impulse = 1'b1;
          end
        end
      end
      r.x1 = clamp32(x1); r.y1 = clamp32(y1); r.vx1 = clamp32(vx1); r.vy1 = clamp32(vy1);
      r.x2 = clamp32(x2); r.y2 = clamp32(y2); r.vx2 = clamp32(vx2); r.vy2 = clamp32(vy2);
      return r;
    endfunction

    function void note_pair(circle_pair_t p);
      pending.push_back(resolve_contact(p));
    endfunction

    function void cmp_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(resolved_pair_t a);
      resolved_pair_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, actual x1 %0d",
                 $time, a.x1);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp_field("new_first_x", e.x1, a.x1);
      cmp_field("new_first_y", e.y1, a.y1);
      cmp_field("new_first_vx", e.vx1, a.vx1);
      cmp_field("new_first_vy", e.vy1, a.vy1);
      cmp_field("new_second_x", e.x2, a.x2);
      cmp_field("new_second_y", e.y2, a.y2);
      cmp_field("new_second_vx", e.vx2, a.vx2);
      cmp_field("new_second_vy", e.vy2, a.vy2);
      cmp_field("overlapping", e.overlapping, a.overlapping);
      cmp_field("impulse_applied", e.impulse, a.impulse);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  contact_scoreboard sb;

  cpcr_in_if  in_chan();
  cpcr_out_if out_chan();

  circle_pair_collision_resolve dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_pair(circle_pair_t p);
    while (!quiet && $urandom_range(99) < 16) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.first_x = p.x1; in_chan.first_y = p.y1;
    in_chan.first_vx = p.vx1; in_chan.first_vy = p.vy1;
    in_chan.first_radius = p.r1;
    in_chan.second_x = p.x2; in_chan.second_y = p.y2;
    in_chan.second_vx = p.vx2; in_chan.second_vy = p.vy2;
    in_chan.second_radius = p.r2;
    forever begin
      @(posedge clk);
      if (in_chan.ready) begin
        sb.note_pair(p);
        @(negedge clk);
        break;
      end
      @(negedge clk);
    end
  endtask

  function automatic circle_pair_t make_pair(longint x1, longint y1, longint vx1, longint vy1,
                                             longint r1, longint x2, longint y2,
                                             longint vx2, longint vy2, longint r2);
    circle_pair_t p;
    p.x1 = 32'(x1); p.y1 = 32'(y1); p.vx1 = 32'(vx1); p.vy1 = 32'(vy1); p.r1 = 24'(r1);
    p.x2 = 32'(x2); p.y2 = 32'(y2); p.vx2 = 32'(vx2); p.vy2 = 32'(vy2); p.r2 = 24'(r2);
    return p;
  endfunction

  // random pair, mostly in contact with random content
  function automatic circle_pair_t random_pair();
    circle_pair_t p;
    longint mind, dx, dy, x1, y1;
    p.x1 = $urandom; p.y1 = $urandom; p.vx1 = $urandom; p.vy1 = $urandom;
    p.x2 = $urandom; p.y2 = $urandom; p.vx2 = $urandom; p.vy2 = $urandom;
    p.r1 = 24'($urandom); p.r2 = 24'($urandom);
    if ($urandom_range(99) < 20) return p;
    if ($urandom_range(99) < 75) begin
      p.r1 = 24'($urandom_range(32'h40000, 1));
      p.r2 = 24'($urandom_range(32'h40000, 0));
    end
    if ($urandom_range(1)) begin
      p.vx1 = $signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000;
      p.vy1 = $signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000;
      p.vx2 = $signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000;
      p.vy2 = $signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000;
    end
    if ($urandom_range(99) < 70) begin
      p.x1 = $signed($urandom_range(32'hFF_FFFF)) - 32'sh80_0000;
      p.y1 = $signed($urandom_range(32'hFF_FFFF)) - 32'sh80_0000;
    end
    mind = longint'(p.r1) + longint'(p.r2);
    if (mind < 2) mind = 2;
    dx = longint'($urandom_range(32'(2 * mind - 2))) - (mind - 1);
    dy = longint'($urandom_range(32'(2 * mind - 2))) - (mind - 1);
    x1 = p.x1;
    y1 = p.y1;
    p.x2 = 32'(x1 + dx);
    p.y2 = 32'(y1 + dy);
    return p;
  endfunction

  // result side: random stalls, checks at the rising edge
  initial begin
    resolved_pair_t a;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready = quiet || ($urandom_range(99) >= 16);
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        a.x1 = out_chan.new_first_x;   a.y1 = out_chan.new_first_y;
        a.vx1 = out_chan.new_first_vx; a.vy1 = out_chan.new_first_vy;
        a.x2 = out_chan.new_second_x;  a.y2 = out_chan.new_second_y;
        a.vx2 = out_chan.new_second_vx; a.vy2 = out_chan.new_second_vy;
        a.overlapping = out_chan.overlapping;
        a.impulse = out_chan.impulse_applied;
        sb.check_result(a);
      end
    end
  end

  // stimulus
  initial begin
    int n;
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.first_x = '0; in_chan.first_y = '0; in_chan.first_vx = '0;
    in_chan.first_vy = '0; in_chan.first_radius = '0;
    in_chan.second_x = '0; in_chan.second_y = '0; in_chan.second_vx = '0;
    in_chan.second_vy = '0; in_chan.second_radius = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // far apart, no contact
    send_pair(make_pair(0, 0, 100, 200, 32'h10000, 32'h50000, 0, 3, 4, 32'h10000));
    // coincident centres
    send_pair(make_pair(32'h30000, 32'h30000, 5, 6, 32'h10000, 32'h30000, 32'h30000,
                        7, 8, 32'h10000));
    // touching exactly, distance equal to the sum of radii
    send_pair(make_pair(0, 0, 65536, 0, 32'h10000, 32'h20000, 0, 0, 0, 32'h10000));
    // approaching head on
    send_pair(make_pair(0, 0, 65536, 0, 32'h10000, 32'h18000, 0, -65536, 0, 32'h10000));
    // receding
    send_pair(make_pair(0, 0, -65536, 0, 32'h10000, 32'h18000, 0, 65536, 0, 32'h10000));
    // diagonal approach
    send_pair(make_pair(0, 0, 65536, 65536, 32'h20000, 32'h10000, 32'h10000, 0, 0,
                        32'h20000));
    // zero radii
    send_pair(make_pair(0, 0, 1, 1, 0, 1, 0, 0, 0, 0));
    // largest radii, small offset
    send_pair(make_pair(0, 0, 0, 0, 32'hFF_FFFF, 1, 0, 0, 0, 32'hFF_FFFF));
    // largest radii, centre offset by a whole radius
    send_pair(make_pair(-64'sd2147483648, 0, 0, 0, 32'hFF_FFFF, -64'sd2130706433, 5, 0, 0,
                        32'hFF_FFFF));
    // position saturation at both ends
    send_pair(make_pair(-64'sd2147483648, -64'sd2147483648, 0, 0, 32'hFF_FFFF,
                        -64'sd2147483647, -64'sd2147483647, 0, 0, 32'hFF_FFFF));
    send_pair(make_pair(64'sd2147483646, 64'sd2147483646, 0, 0, 32'hFF_FFFF,
                        64'sd2147483647, 64'sd2147483647, 0, 0, 32'hFF_FFFF));
    // velocity saturation
    send_pair(make_pair(0, 0, 64'sd2147483647, 64'sd2147483647, 32'h10000, 32'h100, 0,
                        -64'sd2147483648, -64'sd2147483648, 32'h10000));
    send_pair(make_pair(0, 0, -64'sd2147483648, 0, 32'h10000, -32'sh100, 0,
                        64'sd2147483647, 0, 32'h10000));
    // all ones and all zeros
    send_pair(make_pair(-1, -1, -1, -1, 32'hFF_FFFF, -1, -1, -1, -1, 32'hFF_FFFF));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // random part, with a stretch of no idling in the middle
    for (n = 0; n < 450; n++) begin
      quiet = (n >= 150 && n < 250);
      send_pair(random_pair());
    end
    quiet = 1'b0;
    in_chan.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("testbench failed");
    $finish;
  end

endmodule

@@ circle_pair_collision_resolve.f @@
+incdir+rtl
rtl/cpcr_pkg.sv
rtl/cpcr_if.sv
rtl/cpcr_front.sv
rtl/cpcr_sqrt_step.sv
rtl/cpcr_div_step.sv
rtl/cpcr_resolve.sv
rtl/circle_pair_collision_resolve.sv
rtl/cpcr_checker.sv
dv/testbench.sv
